// File: rtl/gpio_port_with_change_irq_top_defines.svh
// Assertion macros used by the RTL of the GPIO port top module.
`ifndef GPIO_PORT_WITH_CHANGE_IRQ_TOP_DEFINES_SVH
`define GPIO_PORT_WITH_CHANGE_IRQ_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GPCI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gpio port: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GPCI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gpio port: next-cycle check failed");

`endif

// File: rtl/gpci_pkg.sv
package gpci_pkg;

  // Pin count of the port and the width of the packed mode field.
  localparam int unsigned PinCount = 24;
  localparam int unsigned ModeW    = 2 * PinCount;

  // Bus function codes carried with each tick.
  typedef enum logic [1:0] {
    FUNC_IDLE  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2
  } func_e;

  // Word offsets of the registers inside the window.
  localparam logic [29:0] RegOut    = 30'd0;
  localparam logic [29:0] RegModeLo = 30'd1;
  localparam logic [29:0] RegModeHi = 30'd2;

  // Configuration register indexes.
  localparam logic CfgBase   = 1'b0;
  localparam logic CfgWindow = 1'b1;

  // Pin modes.
  localparam logic [1:0] ModeIn    = 2'd0;
  localparam logic [1:0] ModeOut   = 2'd1;
  localparam logic [1:0] ModeInIrq = 2'd2;

  // One result item.
  typedef struct packed {
    logic                address_error;
    logic                irq;
    logic [PinCount-1:0] pads_out;
    logic [31:0]         read_word;
  } res_t;

  localparam int unsigned ResW = $bits(res_t);

endpackage

// File: rtl/gpio_port_with_change_irq_top.sv
// GPIO port with pin-change interrupt.
// Each tick's result is registered in the output register, or in the skid entry under a stall.
// Throughput: one tick per cycle while s_tready_o is high; s_tready_o drops while the skid entry is full.
// All pin state is updated in the cycle of the transfer, so back-to-back ticks see each other.
// Reset (async, active low) clears latch, modes, pads, base 0 and window 16 bytes.
module gpio_port_with_change_irq_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // Tick input: func[1:0], bus_address[33:2], write_word[65:34], pins_in[89:66].
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [95:0] s_tdata_i,
  // Result: read_word[31:0], pads_out[55:32], irq[56], address_error[57].
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [63:0] m_tdata_o
);

  `include "gpio_port_with_change_irq_top_defines.svh"

  localparam int unsigned Pc = gpci_pkg::PinCount;

  // Configuration registers.
  logic [31:0] base_q;
  logic [12:0] window_q;

  // Port state.
  logic [31:0]    latch_q, latch_d;
  logic [31:0]    mode_lo_q, mode_lo_d;
  logic [15:0]    mode_hi_q, mode_hi_d;
  logic [Pc-1:0]  pad_q, pad_d;
  logic [Pc-1:0]  prev_q;

  // Output register and skid entry.
  logic             out_valid_q, skid_valid_q;
  gpci_pkg::res_t   out_q, skid_q, res_w;

  // Unpacked input fields.
  logic [1:0]    func_w;
  logic [31:0]   addr_w;
  logic [31:0]   wdata_w;
  logic [Pc-1:0] ext_w;

  logic                       acc_w;
  logic [gpci_pkg::ModeW-1:0] modes_old_w, modes_new_w;
  logic [Pc-1:0]              outs_w, ins_w, irqp_w, pad_pre_w;
  logic [31:0]                off_w;
  logic                       access_w, err_w;
  logic [29:0]                reg_w;

  assign func_w  = s_tdata_i[1:0];
  assign addr_w  = s_tdata_i[33:2];
  assign wdata_w = s_tdata_i[65:34];
  assign ext_w   = s_tdata_i[66 +: Pc];

  assign s_tready_o = ~skid_valid_q;
  assign acc_w      = s_tvalid_i & s_tready_o;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      window_q <= 13'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gpci_pkg::CfgBase:   base_q   <= cfg_wdata_i;
        gpci_pkg::CfgWindow: window_q <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  // Per-pin mode decode before and after a possible mode write.
  assign modes_old_w = {mode_hi_q, mode_lo_q};
  assign modes_new_w = {mode_hi_d, mode_lo_d};

  always_comb begin
    for (int p = 0; p < Pc; p++) begin
      outs_w[p] = (modes_old_w[2*p +: 2] == gpci_pkg::ModeOut);
      ins_w[p]  = (modes_old_w[2*p +: 2] == gpci_pkg::ModeIn) ||
                  (modes_old_w[2*p +: 2] == gpci_pkg::ModeInIrq);
      irqp_w[p] = (modes_new_w[2*p +: 2] == gpci_pkg::ModeInIrq);
    end
  end

  // Non-output pins sample the external levels at the start of the tick.
  assign pad_pre_w = (pad_q & outs_w) | (ext_w & ~outs_w);

  // Window decode, without wrap.
  assign access_w = (func_w == gpci_pkg::FUNC_READ) || (func_w == gpci_pkg::FUNC_WRITE);
  assign off_w    = addr_w - base_q;
  assign err_w    = access_w && ((addr_w < base_q) || (off_w >= {19'd0, window_q}));
  assign reg_w    = off_w[31:2];

  // Register access and result of one tick.
  always_comb begin
    latch_d   = latch_q;
    mode_lo_d = mode_lo_q;
    mode_hi_d = mode_hi_q;
    pad_d     = pad_pre_w;
    res_w     = '0;
    if (access_w && !err_w) begin
      if (func_w == gpci_pkg::FUNC_WRITE) begin
        case (reg_w)
          gpci_pkg::RegOut: begin
            latch_d = wdata_w;
            pad_d   = (pad_pre_w & ~outs_w) | (wdata_w[Pc-1:0] & outs_w);
          end
          gpci_pkg::RegModeLo: mode_lo_d = wdata_w;
          gpci_pkg::RegModeHi: mode_hi_d = wdata_w[15:0];
          default: ;
        endcase
      end else begin
        case (reg_w)
          gpci_pkg::RegOut: begin
            res_w.read_word = (latch_q & ~{{(32-Pc){1'b0}}, ins_w}) |
                              {{(32-Pc){1'b0}}, pad_pre_w & ins_w};
          end
          gpci_pkg::RegModeLo: res_w.read_word = mode_lo_q;
          gpci_pkg::RegModeHi: res_w.read_word = {16'd0, mode_hi_q};
          default: ;
        endcase
      end
    end
    res_w.pads_out      = pad_d;
    res_w.irq           = |((pad_d ^ prev_q) & irqp_w);
    res_w.address_error = err_w;
  end

  // Port state is updated on every transferred tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q   <= '0;
      mode_lo_q <= '0;
      mode_hi_q <= '0;
      pad_q     <= '0;
      prev_q    <= '0;
    end else if (acc_w) begin
      latch_q   <= latch_d;
      mode_lo_q <= mode_lo_d;
      mode_hi_q <= mode_hi_d;
      pad_q     <= pad_d;
      prev_q    <= pad_d;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_tready_i) begin
      out_valid_q  <= skid_valid_q | acc_w;
      skid_valid_q <= 1'b0;
    end else if (acc_w) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_tready_i) begin
      out_q <= skid_valid_q ? skid_q : res_w;
    end else if (acc_w) begin
      skid_q <= res_w;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(64-gpci_pkg::ResW){1'b0}}, out_q};

  // The skid entry is only filled behind a waiting result.
  `GPCI_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
  // An access outside the window leaves the latch and the mode registers untouched.
  `GPCI_ASSERT_NEXT(a_err_no_change, acc_w && err_w,
                    $stable(latch_q) && $stable(mode_lo_q) && $stable(mode_hi_q))
  // A tick without access never changes the latch or the modes.
  `GPCI_ASSERT_NEXT(a_idle_no_change, acc_w && !access_w,
                    $stable(latch_q) && $stable(mode_lo_q) && $stable(mode_hi_q))

endmodule
